// ===== hw/rtl/mm_pkg.sv =====
// Shared types and constants for the matrix product engine.
// No dependencies.
`timescale 1ns / 1ps

package mm_pkg;

	localparam int SIZE_W    = 5;
	localparam int IDX_IN_W  = 4;
	localparam int VALUE_W   = 16;
	localparam int PRODUCT_W = 36;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 3;

	typedef enum logic [1:0] {
		REQ_WRITE_A = 2'd0,
		REQ_WRITE_B = 2'd1,
		REQ_COMPUTE = 2'd2,
		REQ_NONE    = 2'd3
	} req_type_t;

	typedef logic [IDX_IN_W-1:0]         idx_in_t;
	typedef logic signed [VALUE_W-1:0]   value_t;
	typedef logic signed [PRODUCT_W-1:0] product_t;

	localparam logic [APB_AW-1:0] ADDR_SIZE_IN_USE = 3'd0;
	localparam logic [SIZE_W-1:0] SIZE_RESET       = 5'd16;

endpackage

// ===== hw/rtl/matrix_multiply.sv =====
// Matrix product engine: A and B element stores plus one multiply-accumulate unit.
// Depends on mm_pkg.
// Usage:
//   Command channel: an item is taken at a rising edge with start high and busy
//   low. req_type selects write A, write B or compute one product row.
//   A write stores one element; busy stays low.
//   A compute of row i (i < n) walks k inside j through one shared MAC fed
//   by one read port on each store, so busy stays high while it runs. One
//   result per column follows, ordered by column, the final one marked by
//   last. A row at or beyond n, or an unused code, emits nothing and keeps
//   busy low.
//   Results: done is high for exactly one cycle per result; the receiver
//   cannot stall, so no backpressure exists.
//   Configuration: APB register size_in_use at byte address 0, written only
//   while idle (user's duty, not enforced); values above MAX_DIM act as MAX_DIM.
//   Reset: clears the sequencer, the pipeline flags and size_in_use (16). The
//   element stores are not cleared; read only elements already written.
`timescale 1ns / 1ps

module matrix_multiply #(
	parameter int MAX_DIM    = 16,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mm_pkg::APB_AW-1:0]     paddr,
	input  logic [mm_pkg::APB_DW-1:0]     pwdata,
	output logic [mm_pkg::APB_DW-1:0]     prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  mm_pkg::idx_in_t               row,
	input  mm_pkg::idx_in_t               col,
	input  mm_pkg::value_t                value,
	output logic                          done,
	output mm_pkg::idx_in_t               out_row,
	output mm_pkg::idx_in_t               out_col,
	output mm_pkg::product_t              product,
	output logic                          last
);

	import mm_pkg::*;

	localparam int IDX_W    = $clog2(MAX_DIM);
	localparam int ADDR_W   = 2 * IDX_W;
	localparam int DEPTH    = 1 << ADDR_W;
	localparam int MUL_W    = 2 * ELEM_WIDTH;

	typedef logic signed [ELEM_WIDTH-1:0] elem_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [ADDR_W-1:0]            addr_t;

	typedef struct packed {
		logic  first;
		logic  lastk;
		logic  lastj;
		idx_t  j;
	} tag_t;

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] n_eff;
	idx_t              n_m1;

	logic              issuing_q;
	idx_in_t           row_q;
	idx_t              row_idx_q;
	idx_t              j_q;
	idx_t              k_q;

	logic              v_s1;
	tag_t              tag_s1;
	elem_t             a_rd_s1;
	elem_t             b_rd_s1;

	logic              v_s2;
	tag_t              tag_s2;
	logic signed [MUL_W-1:0] prod_s2;

	product_t          acc_q;
	product_t          sum;

	logic              done_q;
	idx_in_t           out_row_q;
	idx_in_t           out_col_q;
	product_t          product_q;
	logic              last_q;

	elem_t             mem_a [DEPTH];
	elem_t             mem_b [DEPTH];

	logic              take;
	logic              in_store;
	logic              wr_a;
	logic              wr_b;
	logic              go;
	addr_t             wr_addr;
	addr_t             a_addr;
	addr_t             b_addr;
	elem_t             wr_elem;
	logic signed [31:0] value_ext;
	tag_t              tag_issue;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ADDR_SIZE_IN_USE[2]) ? APB_DW'(size_q) : '0;

	always_comb begin
		if (int'(size_q) > MAX_DIM) begin
			n_eff = SIZE_W'(MAX_DIM);
		end else begin
			n_eff = size_q;
		end
		n_m1 = IDX_W'(n_eff - SIZE_W'(1));
	end

	assign take      = start && !busy;
	assign in_store  = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
	assign wr_a      = take && (req_type == REQ_WRITE_A) && in_store;
	assign wr_b      = take && (req_type == REQ_WRITE_B) && in_store;
	assign go        = take && (req_type == REQ_COMPUTE) && (n_eff != '0)
	                   && (SIZE_W'(row) < n_eff);
	assign value_ext = 32'(value);
	assign wr_elem   = value_ext[ELEM_WIDTH-1:0];
	assign wr_addr   = {IDX_W'(row), IDX_W'(col)};
	assign a_addr    = {row_idx_q, k_q};
	assign b_addr    = {k_q, j_q};

	assign tag_issue.first = (k_q == '0);
	assign tag_issue.lastk = (k_q == n_m1);
	assign tag_issue.lastj = (j_q == n_m1);
	assign tag_issue.j     = j_q;

	assign busy = issuing_q || v_s1 || v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && pready
		             && (paddr[2] == ADDR_SIZE_IN_USE[2])) begin
			size_q <= pwdata[SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[wr_addr] <= wr_elem;
		end
		a_rd_s1 <= mem_a[a_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[wr_addr] <= wr_elem;
		end
		b_rd_s1 <= mem_b[b_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			j_q       <= '0;
			k_q       <= '0;
		end else if (go) begin
			issuing_q <= 1'b1;
			j_q       <= '0;
			k_q       <= '0;
		end else if (issuing_q) begin
			if (tag_issue.lastk) begin
				k_q <= '0;
				if (tag_issue.lastj) begin
					issuing_q <= 1'b0;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end else begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			row_q     <= row;
			row_idx_q <= IDX_W'(row);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= issuing_q;
			v_s2   <= v_s1;
			done_q <= v_s2 && tag_s2.lastk;
		end
	end

	assign sum = (tag_s2.first ? '0 : acc_q) + PRODUCT_W'(prod_s2);

	always_ff @(posedge clk) begin
		tag_s1  <= tag_issue;
		tag_s2  <= tag_s1;
		prod_s2 <= MUL_W'(a_rd_s1) * MUL_W'(b_rd_s1);
		if (v_s2) begin
			acc_q <= sum;
		end
		if (v_s2 && tag_s2.lastk) begin
			out_row_q <= row_q;
			out_col_q <= IDX_IN_W'(tag_s2.j);
			product_q <= sum;
			last_q    <= tag_s2.lastj;
		end
	end

	assign done    = done_q;
	assign out_row = out_row_q;
	assign out_col = out_col_q;
	assign product = product_q;
	assign last    = last_q;

endmodule

// ===== test/mm_checker.sv =====
// Checker for matrix_multiply: mirrors size_in_use and both element stores from the
// observed APB and command words, predicts every product row and compares each result.
// Depends on mm_pkg.
`timescale 1ns / 1ps

module mm_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [mm_pkg::APB_AW-1:0] paddr,
	input  logic [mm_pkg::APB_DW-1:0] pwdata,
	input  logic [mm_pkg::APB_DW-1:0] prdata,
	input  logic                      pready,
	input  logic                      start,
	input  logic                      busy,
	input  logic [1:0]                req_type,
	input  mm_pkg::idx_in_t           row,
	input  mm_pkg::idx_in_t           col,
	input  mm_pkg::value_t            value,
	input  logic                      done,
	input  mm_pkg::idx_in_t           out_row,
	input  mm_pkg::idx_in_t           out_col,
	input  mm_pkg::product_t          product,
	input  logic                      last,
	output int                        errors,
	output int                        pending
);
	import mm_pkg::*;

	localparam int DIM = 16;

	typedef struct packed {
		idx_in_t  at_row;
		idx_in_t  at_col;
		product_t sum;
		logic     last_col;
	} product_word_t;

	product_word_t     expected_products[$];
	product_word_t     oldest;
	value_t            a_elems [DIM][DIM];
	value_t            b_elems [DIM][DIM];
	logic [SIZE_W-1:0] size_reg = SIZE_RESET;

	initial begin
		errors = 0;
		pending = 0;
	end

	task automatic report(input string what, input longint got, input longint want);
		if (errors < 100)
			$display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	function automatic void predict_product_row(input idx_in_t r);
		int n;
		longint acc;
		product_word_t w;
		n = (size_reg > DIM) ? DIM : int'(size_reg);
		if (int'(r) >= n)
			return;
		for (int j = 0; j < n; j++) begin
			acc = 0;
			for (int k = 0; k < n; k++)
				acc += longint'(a_elems[r][k]) * longint'(b_elems[k][j]);
			w.at_row = r;
			w.at_col = j[IDX_IN_W-1:0];
			w.sum = acc[PRODUCT_W-1:0];
			w.last_col = (j == n - 1);
			expected_products.push_back(w);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (done !== 1'b0) begin
				if (expected_products.size() == 0) begin
					report("unexpected product", product, 0);
				end else begin
					oldest = expected_products.pop_front();
					if (out_row !== oldest.at_row)
						report("out_row", out_row, oldest.at_row);
					if (out_col !== oldest.at_col)
						report("out_col", out_col, oldest.at_col);
					if (product !== oldest.sum)
						report("product", product, signed'(oldest.sum));
					if (last !== oldest.last_col)
						report("last", last, oldest.last_col);
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr == ADDR_SIZE_IN_USE)
						size_reg = pwdata[SIZE_W-1:0];
				end else if (paddr == ADDR_SIZE_IN_USE && prdata !== APB_DW'(size_reg)) begin
					report("size_in_use readback", prdata, size_reg);
				end
			end
			if (start && !busy) begin
				case (req_type)
					REQ_WRITE_A: a_elems[row][col] = value;
					REQ_WRITE_B: b_elems[row][col] = value;
					REQ_COMPUTE: predict_product_row(row);
					default: ;
				endcase
			end
			pending = expected_products.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
// Top of the matrix_multiply testbench: clock, reset, APB programming of size_in_use
// and command words in random bursts; mm_checker does the prediction and comparison.
// Depends on mm_pkg, matrix_multiply and mm_checker.
`timescale 1ns / 1ps

module testbench;
	import mm_pkg::*;

	localparam int DIM = 16;
	localparam int SETTLE_CYCLES = 24;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        req_type = REQ_NONE;
	idx_in_t           row = '0;
	idx_in_t           col = '0;
	value_t            value = '0;
	logic              done;
	idx_in_t           out_row;
	idx_in_t           out_col;
	product_t          product;
	logic              last;
	int                errors;
	int                pending;
	logic              took_word = 1'b0;
	bit                a_written [DIM][DIM];
	bit                b_written [DIM][DIM];
	int                size_now = SIZE_RESET;
	int                burst_left = 0;
	int                phase_sizes [8] = '{1, 3, 5, 2, 8, 4, 16, 7};

	matrix_multiply u_top (.*);

	mm_checker u_checker (.*);

	always #1 clk = ~clk;

	always @(posedge clk) took_word <= start && !busy;

	initial begin
		#2000000;
		$display("matrix_multiply verification failed");
		$finish;
	end

	function automatic int live_size();
		return (size_now > DIM) ? DIM : size_now;
	endfunction

	function automatic value_t pick_value();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sd0;
			3: return -16'sd1;
			default: return value_t'($urandom);
		endcase
	endfunction

	function automatic idx_in_t pick_index(input int n);
		if (n == 0 || $urandom_range(0, 4) == 0)
			return idx_in_t'($urandom);
		return idx_in_t'($urandom_range(0, n - 1));
	endfunction

	task automatic send_word(input req_type_t kind, input idx_in_t r, input idx_in_t c,
			input value_t v);
		start <= 1'b1;
		req_type <= kind;
		row <= r;
		col <= c;
		value <= v;
		@(negedge clk);
		while (!took_word) @(negedge clk);
	endtask

	task automatic issue(input req_type_t kind, input idx_in_t r, input idx_in_t c,
			input value_t v);
		send_word(kind, r, c, v);
		if (kind == REQ_WRITE_A)
			a_written[r][c] = 1'b1;
		if (kind == REQ_WRITE_B)
			b_written[r][c] = 1'b1;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat (($urandom_range(0, 7) == 0) ? $urandom_range(7, 300) : $urandom_range(1, 6))
				@(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
		end
	endtask

	task automatic drain_products();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_transfer(input logic is_write, input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= ADDR_SIZE_IN_USE;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_size(input int s);
		drain_products();
		apb_transfer(1'b1, APB_DW'(s));
		apb_transfer(1'b0, '0);
		size_now = s;
	endtask

	// fill every element the row product reads before asking for it
	task automatic compute_row(input idx_in_t r);
		int n;
		n = live_size();
		if (int'(r) < n) begin
			for (int k = 0; k < n; k++)
				if (!a_written[r][k])
					issue(REQ_WRITE_A, r, idx_in_t'(k), pick_value());
			for (int k = 0; k < n; k++)
				for (int j = 0; j < n; j++)
					if (!b_written[k][j])
						issue(REQ_WRITE_B, idx_in_t'(k), idx_in_t'(j), pick_value());
		end
		issue(REQ_COMPUTE, r, idx_in_t'($urandom), value_t'($urandom));
	endtask

	initial begin
		int n;
		int quota;
		int pick;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		apb_transfer(1'b0, '0);

		program_size(2);
		issue(REQ_WRITE_A, 4'd0, 4'd0, 16'sh7FFF);
		issue(REQ_WRITE_A, 4'd0, 4'd1, 16'sh8000);
		issue(REQ_WRITE_A, 4'd1, 4'd0, -16'sd1);
		issue(REQ_WRITE_A, 4'd1, 4'd1, 16'sd0);
		issue(REQ_WRITE_B, 4'd0, 4'd0, 16'sh8000);
		issue(REQ_WRITE_B, 4'd0, 4'd1, 16'sh7FFF);
		issue(REQ_WRITE_B, 4'd1, 4'd0, 16'sh8000);
		issue(REQ_WRITE_B, 4'd1, 4'd1, 16'sd1);
		compute_row(4'd0);
		compute_row(4'd1);
		compute_row(4'd2);
		compute_row(4'd15);
		issue(REQ_NONE, 4'd15, 4'd15, -16'sd1);
		issue(REQ_WRITE_A, 4'd15, 4'd15, 16'sh8000);
		issue(REQ_WRITE_B, 4'd15, 4'd15, 16'sh7FFF);
		compute_row(4'd1);

		program_size(16);
		for (int k = 0; k < DIM; k++) begin
			issue(REQ_WRITE_A, 4'd15, idx_in_t'(k), 16'sh8000);
			issue(REQ_WRITE_B, idx_in_t'(k), 4'd0, 16'sh8000);
			issue(REQ_WRITE_B, idx_in_t'(k), 4'd15, 16'sh7FFF);
		end
		compute_row(4'd15);
		compute_row(4'd0);

		program_size(0);
		compute_row(4'd0);
		program_size(31);
		compute_row(4'd15);

		foreach (phase_sizes[p]) begin
			program_size(phase_sizes[p]);
			n = live_size();
			quota = (n == DIM) ? 4 : 6;
			for (int i = 0; i < quota; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					issue((pick < 35) ? REQ_WRITE_A : REQ_WRITE_B, pick_index(n),
						pick_index(n), pick_value());
				else if (pick < 92)
					compute_row(pick_index(n));
				else
					issue(REQ_NONE, idx_in_t'($urandom), idx_in_t'($urandom),
						value_t'($urandom));
				if ($urandom_range(0, 39) == 0)
					drain_products();
			end
		end

		drain_products();
		if (errors == 0)
			$display("matrix_multiply verification clean");
		else
			$display("matrix_multiply verification failed");
		$finish;
	end

endmodule
